/* rtl/nmms_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nmms_pkg
// Shared sizes, request types and arithmetic helpers for the mixture
// statistics block.
// ----------------------------------------------------------------------------
package nmms_pkg;

   localparam int MAX_CLUSTERS = 8;
   localparam int MAX_DIMS     = 16;
   localparam int NUM_CELLS    = MAX_CLUSTERS * MAX_DIMS;

   localparam int ADDR_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int BC_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int BD_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int KC_W   = $clog2(MAX_CLUSTERS + 1);
   localparam int KD_W   = $clog2(MAX_DIMS + 1);

   localparam int MODE_W  = 2;
   localparam int CL_W    = 3;
   localparam int EL_W    = 4;
   localparam int VAL_W   = 16;
   localparam int NCFG_W  = 4;
   localparam int DCFG_W  = 5;
   localparam int CSR_W   = 5;
   localparam int CSRI_W  = 1;

   localparam int SQ_W    = 32;
   localparam int DIST_W  = 40;
   localparam int VSUM_W  = 48;
   localparam int CNT_W   = 24;
   localparam int VAR_W   = 32;
   localparam int WT_W    = 17;
   localparam int FRAC_W  = 16;

   localparam logic [CSRI_W-1:0] CSR_CLUSTERS = 1'd0;
   localparam logic [CSRI_W-1:0] CSR_DIMS     = 1'd1;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD   = 2'd0,
      MODE_SAMPLE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                 mode;
      logic [CL_W-1:0]          cl;
      logic [EL_W-1:0]          el;
      logic signed [VAL_W-1:0]  value;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic              we;
      logic [CSRI_W-1:0] index;
      logic [CSR_W-1:0]  wdata;
   } csr_write_type;

   function automatic logic [ADDR_W-1:0] cell_addr(int unsigned c, int unsigned d);
      return ADDR_W'(c * MAX_DIMS + d);
   endfunction

   function automatic logic [SQ_W-1:0] sq_diff(logic signed [VAL_W-1:0] a,
                                                logic signed [VAL_W-1:0] b);
      logic signed [VAL_W:0] d;
      logic [VAL_W:0]        m;
      d = VAL_W'(0) + {a[VAL_W-1], a} - {b[VAL_W-1], b};
      m = d[VAL_W] ? (~d + 1'b1) : d;
      return m[VAL_W-1:0] * m[VAL_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/nmms_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nmms_req_if / nmms_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface nmms_req_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           mode;
   logic [2:0]           cluster_index;
   logic [3:0]           element_index;
   logic signed [15:0]   value;
   logic                 last_element;
   modport source (output valid, mode, cluster_index, element_index, value,
                   last_element, input ready);
   modport sink (input valid, mode, cluster_index, element_index, value,
                 last_element, output ready);
endinterface

interface nmms_rsp_if;
   logic         valid;
   logic         ready;
   logic [31:0]  variance;
   logic [16:0]  weight;
   logic [23:0]  vector_count;
   logic         empty_cluster;
   modport source (output valid, variance, weight, vector_count, empty_cluster,
                   input ready);
   modport sink (input valid, variance, weight, vector_count, empty_cluster,
                 output ready);
endinterface
`default_nettype wire

/* rtl/nmms_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nmms_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nmms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

/* rtl/nmms_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nmms_front
// Accepts requests, decodes the mode and queues them for the back end.
// ----------------------------------------------------------------------------
module nmms_front (
   input  wire logic          clock,
   input  wire logic          reset,
   nmms_req_if.sink           req_chan,
   output nmms_pkg::req_type  q_req,
   output logic               q_valid,
   input  wire logic          q_pop
);
   import nmms_pkg::*;

   req_type    entry_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   req_type    dec;

   assign req_chan.ready = (fill_ff != 2'd2);
   assign push    = req_chan.valid && req_chan.ready;
   assign q_valid = (fill_ff != 2'd0);
   assign q_req   = entry_ff[rp_ff];

   always_comb begin
      case (req_chan.mode)
         MODE_LOAD:   dec.mode = MODE_LOAD;
         MODE_SAMPLE: dec.mode = MODE_SAMPLE;
         MODE_READ:   dec.mode = MODE_READ;
         default:     dec.mode = MODE_CLEAR;
      endcase
      dec.cl    = req_chan.cluster_index;
      dec.el    = req_chan.element_index;
      dec.value = req_chan.value;
      dec.last  = req_chan.last_element;
   end

   always_comb begin
      wp_in   = wp_ff ^ push;
      rp_in   = rp_ff ^ (q_pop && q_valid);
      fill_in = fill_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wp_ff] <= dec;
      end
      if (reset) begin
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         fill_ff <= fill_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/nmms_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nmms_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nmms_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [nmms_pkg::VSUM_W-1:0]   dividend,
   input  wire logic [nmms_pkg::CNT_W-1:0]    divisor,
   output logic                               done,
   output logic [nmms_pkg::VSUM_W-1:0]        quotient
);
   import nmms_pkg::*;

   localparam int STEP_W = $clog2(VSUM_W + 1);

   logic [VSUM_W-1:0] q_ff, q_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W:0]    rsh;

   assign done     = done_ff;
   assign quotient = q_ff;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rsh     = {rem_ff[CNT_W-1:0], q_ff[VSUM_W-1]};
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[VSUM_W-2:0], 1'b0};
         if (rsh >= {1'b0, dvs_ff}) begin
            rem_in = rsh - {1'b0, dvs_ff};
            q_in[0] = 1'b1;
         end else begin
            rem_in = rsh;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(VSUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/nmms_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nmms_back
// Sequencer: mean loads, distances, nearest-mean assignment, variance sums, clears and readout.
// ----------------------------------------------------------------------------
module nmms_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  nmms_pkg::csr_write_type  csr,
   input  nmms_pkg::req_type        q_req,
   input  wire logic                q_valid,
   output logic                     q_pop,
   nmms_rsp_if.source               rsp_chan
);
   import nmms_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_DRD   = 14'b00000000000010,
      S_DSQ   = 14'b00000000000100,
      S_DADD  = 14'b00000000001000,
      S_BEST  = 14'b00000000010000,
      S_VRD   = 14'b00000000100000,
      S_VSQ   = 14'b00000001000000,
      S_VADD  = 14'b00000010000000,
      S_FIN   = 14'b00000100000000,
      S_RRD   = 14'b00001000000000,
      S_RWAIT = 14'b00010000000000,
      S_DIV1  = 14'b00100000000000,
      S_DIV2  = 14'b01000000000000,
      S_RESP  = 14'b10000000000000
   } state_type;

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [NCFG_W-1:0]    ncfg_ff, ncfg_in;
   logic [DCFG_W-1:0]    dcfg_ff, dcfg_in;
   logic [KD_W-1:0]      k_ff, k_in;
   logic [BC_W-1:0]      best_ff, best_in;
   logic [DIST_W-1:0]    bdist_ff, bdist_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic [VSUM_W-1:0]    hold_ff, hold_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [VAR_W-1:0]     var_ff, var_in;
   logic [WT_W-1:0]      wt_ff, wt_in;
   logic                 empty_ff, empty_in;
   logic [DIST_W-1:0]    dist_ff [MAX_CLUSTERS];
   logic [DIST_W-1:0]    dist_in [MAX_CLUSTERS];
   logic [CNT_W-1:0]     count_ff [MAX_CLUSTERS];
   logic [CNT_W-1:0]     count_in [MAX_CLUSTERS];
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [VAL_W-1:0]     vbuf_ff [MAX_DIMS];
   logic [VAL_W-1:0]     vbuf_in [MAX_DIMS];
   logic [NUM_CELLS-1:0] vvalid_ff, vvalid_in;
   logic [ADDR_W-1:0]    vraddr_ff;
   logic                 ov_ff, ov_in;
   logic [VAR_W-1:0]     ovar_ff, ovar_in;
   logic [WT_W-1:0]      owt_ff, owt_in;
   logic [CNT_W-1:0]     ocnt_ff, ocnt_in;
   logic                 oempty_ff, oempty_in;

   logic                 mean_we;
   logic [ADDR_W-1:0]    mean_waddr, mean_raddr, vsum_waddr, vsum_raddr;
   logic [VAL_W-1:0]     mean_wdata, mean_rdata;
   logic                 vsum_we;
   logic [VSUM_W-1:0]    vsum_wdata, vsum_rdata;
   logic                 div_start, div_done;
   logic [VSUM_W-1:0]    div_a, div_q;
   logic [CNT_W-1:0]     div_b;

   logic [KC_W-1:0]      nc;
   logic [KD_W-1:0]      nd;
   logic [BC_W-1:0]      kc, cidx;
   logic [DIST_W-1:0]    dist_k;
   logic [CNT_W-1:0]     count_rd;
   logic [DIST_W:0]      dsum;
   logic [VSUM_W:0]      vsum;
   logic                 cl_ok, el_ok;

   nmms_ram #(.WIDTH(VAL_W), .DEPTH(NUM_CELLS)) u_mean (
      .clock(clock), .we(mean_we), .waddr(mean_waddr), .wdata(mean_wdata),
      .raddr(mean_raddr), .rdata(mean_rdata));

   nmms_ram #(.WIDTH(VSUM_W), .DEPTH(NUM_CELLS)) u_vsum (
      .clock(clock), .we(vsum_we), .waddr(vsum_waddr), .wdata(vsum_wdata),
      .raddr(vsum_raddr), .rdata(vsum_rdata));

   nmms_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .done(div_done), .quotient(div_q));

   assign rsp_chan.valid         = ov_ff;
   assign rsp_chan.variance      = ovar_ff;
   assign rsp_chan.weight        = owt_ff;
   assign rsp_chan.vector_count  = ocnt_ff;
   assign rsp_chan.empty_cluster = oempty_ff;

   always_comb begin
      if (ncfg_ff == '0) nc = KC_W'(1);
      else if (int'(ncfg_ff) > MAX_CLUSTERS) nc = KC_W'(MAX_CLUSTERS);
      else nc = KC_W'(ncfg_ff);
      if (dcfg_ff == '0) nd = KD_W'(1);
      else if (int'(dcfg_ff) > MAX_DIMS) nd = KD_W'(MAX_DIMS);
      else nd = KD_W'(dcfg_ff);
   end

   assign kc       = BC_W'(k_ff);
   assign dist_k   = dist_ff[kc];
   assign cidx     = (state_ff == S_FIN) ? best_ff : BC_W'(req_ff.cl);
   assign count_rd = count_ff[cidx];
   assign cl_ok    = int'(req_ff.cl) < MAX_CLUSTERS;
   assign el_ok    = int'(req_ff.el) < MAX_DIMS;

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      ncfg_in   = ncfg_ff;
      dcfg_in   = dcfg_ff;
      k_in      = k_ff;
      best_in   = best_ff;
      bdist_in  = bdist_ff;
      sq_in     = sq_ff;
      hold_in   = hold_ff;
      cnt_in    = cnt_ff;
      var_in    = var_ff;
      wt_in     = wt_ff;
      empty_in  = empty_ff;
      dist_in   = dist_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      vbuf_in   = vbuf_ff;
      vvalid_in = vvalid_ff;
      ov_in     = ov_ff && !rsp_chan.ready;
      ovar_in   = ovar_ff;
      owt_in    = owt_ff;
      ocnt_in   = ocnt_ff;
      oempty_in = oempty_ff;
      q_pop      = 1'b0;
      mean_we    = 1'b0;
      mean_waddr = cell_addr(q_req.cl, q_req.el);
      mean_wdata = q_req.value;
      mean_raddr = cell_addr(k_ff, req_ff.el);
      vsum_we    = 1'b0;
      vsum_waddr = cell_addr(best_ff, k_ff);
      vsum_raddr = cell_addr(best_ff, k_ff);
      div_start  = 1'b0;
      div_a      = '0;
      div_b      = cnt_ff;
      dsum       = {1'b0, dist_k} + (DIST_W + 1)'(sq_ff);
      vsum       = {1'b0, hold_ff} + (VSUM_W + 1)'(sq_ff);
      vsum_wdata = vsum[VSUM_W] ? '1 : vsum[VSUM_W-1:0];

      if (csr.we) begin
         case (csr.index)
            CSR_CLUSTERS: ncfg_in = csr.wdata[NCFG_W-1:0];
            CSR_DIMS:     dcfg_in = csr.wdata[DCFG_W-1:0];
            default:      ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               req_in = q_req;
               case (q_req.mode)
                  MODE_LOAD: begin
                     mean_we = (int'(q_req.cl) < MAX_CLUSTERS) &&
                               (int'(q_req.el) < MAX_DIMS);
                  end
                  MODE_SAMPLE: begin
                     k_in     = '0;
                     best_in  = '0;
                     bdist_in = dist_ff[0];
                     if (int'(q_req.el) < int'(nd)) begin
                        vbuf_in[BD_W'(q_req.el)] = q_req.value;
                        state_in = S_DRD;
                     end else if (q_req.last) begin
                        k_in     = KD_W'(1);
                        state_in = S_BEST;
                     end
                  end
                  MODE_READ: state_in = S_RRD;
                  default: begin
                     for (int i = 0; i < MAX_CLUSTERS; i++) begin
                        dist_in[i]  = '0;
                        count_in[i] = '0;
                     end
                     total_in  = '0;
                     vvalid_in = '0;
                  end
               endcase
            end
         end
         S_DRD: state_in = S_DSQ;
         S_DSQ: begin
            sq_in    = sq_diff(req_ff.value, mean_rdata);
            state_in = S_DADD;
         end
         S_DADD: begin
            dist_in[kc] = dsum[DIST_W] ? '1 : dsum[DIST_W-1:0];
            k_in = k_ff + 1'b1;
            if (KC_W'(k_ff + 1'b1) == nc) begin
               if (req_ff.last) begin
                  k_in     = KD_W'(1);
                  bdist_in = (kc == '0) ? dist_in[0] : dist_ff[0];
                  state_in = S_BEST;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_DRD;
            end
         end
         S_BEST: begin
            if (KC_W'(k_ff) >= nc) begin
               k_in     = '0;
               state_in = S_VRD;
            end else begin
               if (dist_k < bdist_ff) begin
                  best_in  = kc;
                  bdist_in = dist_k;
               end
               k_in = k_ff + 1'b1;
            end
         end
         S_VRD: begin
            mean_raddr = cell_addr(best_ff, k_ff);
            state_in   = S_VSQ;
         end
         S_VSQ: begin
            sq_in    = sq_diff(vbuf_ff[BD_W'(k_ff)], mean_rdata);
            hold_in  = vvalid_ff[vraddr_ff] ? vsum_rdata : '0;
            state_in = S_VADD;
         end
         S_VADD: begin
            vsum_we = 1'b1;
            vvalid_in[cell_addr(best_ff, k_ff)] = 1'b1;
            k_in = k_ff + 1'b1;
            state_in = (k_ff + 1'b1 == nd) ? S_FIN : S_VRD;
         end
         S_FIN: begin
            if (count_rd != '1) count_in[best_ff] = count_rd + 1'b1;
            if (total_ff != '1) total_in = total_ff + 1'b1;
            for (int i = 0; i < MAX_CLUSTERS; i++) dist_in[i] = '0;
            state_in = S_IDLE;
         end
         S_RRD: begin
            vsum_raddr = cell_addr(req_ff.cl, req_ff.el);
            state_in   = S_RWAIT;
         end
         S_RWAIT: begin
            cnt_in   = cl_ok ? count_rd : '0;
            var_in   = '0;
            wt_in    = '0;
            if (!cl_ok || count_rd == '0) begin
               empty_in = 1'b1;
               state_in = S_RESP;
            end else begin
               empty_in  = 1'b0;
               div_start = 1'b1;
               div_a     = (el_ok && vvalid_ff[vraddr_ff]) ? vsum_rdata : '0;
               div_b     = count_rd;
               state_in  = S_DIV1;
            end
         end
         S_DIV1: begin
            if (div_done) begin
               var_in = (div_q[VSUM_W-1:VAR_W] != '0) ? '1 : div_q[VAR_W-1:0];
               if (total_ff != '0) begin
                  div_start = 1'b1;
                  div_a     = VSUM_W'({cnt_ff, FRAC_W'(0)});
                  div_b     = total_ff;
                  state_in  = S_DIV2;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_DIV2: begin
            if (div_done) begin
               wt_in = (div_q > VSUM_W'(1 << FRAC_W)) ? WT_W'(1 << FRAC_W)
                                                      : div_q[WT_W-1:0];
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!ov_ff || rsp_chan.ready) begin
               ov_in     = 1'b1;
               ovar_in   = var_ff;
               owt_in    = wt_ff;
               ocnt_in   = cnt_ff;
               oempty_in = empty_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      k_ff      <= k_in;
      best_ff   <= best_in;
      bdist_ff  <= bdist_in;
      sq_ff     <= sq_in;
      hold_ff   <= hold_in;
      cnt_ff    <= cnt_in;
      var_ff    <= var_in;
      wt_ff     <= wt_in;
      empty_ff  <= empty_in;
      vbuf_ff   <= vbuf_in;
      vraddr_ff <= vsum_raddr;
      ovar_ff   <= ovar_in;
      owt_ff    <= owt_in;
      ocnt_ff   <= ocnt_in;
      oempty_ff <= oempty_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         ncfg_ff   <= NCFG_W'(1);
         dcfg_ff   <= DCFG_W'(16);
         total_ff  <= '0;
         vvalid_ff <= '0;
         ov_ff     <= 1'b0;
         for (int i = 0; i < MAX_CLUSTERS; i++) begin
            dist_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         ncfg_ff   <= ncfg_in;
         dcfg_ff   <= dcfg_in;
         total_ff  <= total_in;
         vvalid_ff <= vvalid_in;
         ov_ff     <= ov_in;
         dist_ff   <= dist_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/nearest_mean_mixture_statistics_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_mean_mixture_statistics_top
// Nearest-mean clustering with per-cluster variance and weight readout.
// ----------------------------------------------------------------------------
// Requests pass a two-entry queue into a sequencer that handles one at a
// time. A mean load or a clear is handled in the idle state. A sample
// element runs a mean RAM read, square and add per cluster in use; one
// outside the dimensions in use is handled in the idle state. A last
// element adds the nearest-mean search, a variance RAM read, square and
// add per dimension in use, and a final step to bump counts. A read of an
// empty cluster passes the read, wait and response states; any other read
// also runs two passes of the 48-step serial divider (variance, then
// weight). Results sit in an output register, so the queue keeps taking
// requests until it is full while a result waits.
// ----------------------------------------------------------------------------
module nearest_mean_mixture_statistics_top (
   input  wire logic         clock,
   input  wire logic         reset,
   nmms_req_if.sink          req_chan,
   nmms_rsp_if.source        rsp_chan,
   input  wire logic         csr_we,
   input  wire logic [0:0]   csr_index,
   input  wire logic [4:0]   csr_wdata
);
   import nmms_pkg::*;

   req_type       q_req;
   logic          q_valid, q_pop;
   csr_write_type csr;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   nmms_front u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan),
      .q_req(q_req), .q_valid(q_valid), .q_pop(q_pop));

   nmms_back u_back (
      .clock(clock), .reset(reset), .csr(csr), .q_req(q_req),
      .q_valid(q_valid), .q_pop(q_pop), .rsp_chan(rsp_chan));
endmodule
`default_nettype wire

/* rtl/nmms_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nmms_checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module nmms_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire logic [31:0]  rsp_variance,
   input wire logic [16:0]  rsp_weight,
   input wire logic [23:0]  rsp_vector_count,
   input wire logic         rsp_empty_cluster
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_variance)
         && $stable(rsp_weight) && $stable(rsp_vector_count))
      else $error("result changed while stalled");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_cluster |-> rsp_variance == 32'd0 && rsp_weight == 17'd0)
      else $error("empty cluster with nonzero statistics");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty_cluster |-> rsp_vector_count != 24'd0)
      else $error("nonempty cluster with zero count");

   a_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weight <= 17'd65536)
      else $error("weight above one");
endmodule

bind nearest_mean_mixture_statistics_top nmms_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready), .rsp_variance(rsp_chan.variance),
   .rsp_weight(rsp_chan.weight), .rsp_vector_count(rsp_chan.vector_count),
   .rsp_empty_cluster(rsp_chan.empty_cluster));
`default_nettype wire

/* bench/nmms_stats_checker.sv */
// ----------------------------------------------------------------------------
// nmms_stats_checker
// Watches the request, result and register ports of the mixture statistics
// block. It keeps its own copy of the means, running distances, variance
// sums and counts, and predicts each read result from them. Every accepted
// result is compared field by field against the oldest pending prediction.
// It reports the number of failures and the number of reads still pending.
// ----------------------------------------------------------------------------
module nmms_stats_checker
   import nmms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   nmms_req_if         req_mon,
   nmms_rsp_if         rsp_mon,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [4:0]  csr_wdata,
   output int          failures,
   output int          outstanding
);

   localparam longint unsigned DIST_SAT = 64'hFF_FFFF_FFFF;
   localparam longint unsigned VSUM_SAT = 64'hFFFF_FFFF_FFFF;
   localparam int unsigned     CNT_SAT  = 32'hFF_FFFF;

   typedef struct {
      logic [VAR_W-1:0] variance;
      logic [WT_W-1:0]  weight;
      logic [CNT_W-1:0] vector_count;
      logic             empty_cluster;
   } stat_result;

   stat_result             expected_stats[$];
   logic [NCFG_W-1:0]      clusters_reg;
   logic [DCFG_W-1:0]      dims_reg;
   logic signed [VAL_W-1:0] mean_cells[NUM_CELLS];
   logic signed [VAL_W-1:0] sample_vec[MAX_DIMS];
   longint unsigned        running_dist[MAX_CLUSTERS];
   longint unsigned        spread_sums[NUM_CELLS];
   int unsigned            members[MAX_CLUSTERS];
   int unsigned            total_vectors;
   int                     fail_total;

   function automatic int active_clusters();
      if (clusters_reg == 0) return 1;
      return (clusters_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(clusters_reg);
   endfunction

   function automatic int active_dims();
      if (dims_reg == 0) return 1;
      return (dims_reg > MAX_DIMS) ? MAX_DIMS : int'(dims_reg);
   endfunction

   function automatic longint unsigned square_gap(logic signed [VAL_W-1:0] a,
                                                  logic signed [VAL_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return longint'(d * d);
   endfunction

   function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b,
                                               longint unsigned lim);
      return (a + b > lim) ? lim : a + b;
   endfunction

   task automatic clear_stats();
      foreach (running_dist[c]) running_dist[c] = 0;
      foreach (spread_sums[a]) spread_sums[a] = 0;
      foreach (members[c]) members[c] = 0;
      total_vectors = 0;
   endtask

   task automatic close_vector();
      int best;
      int a;
      best = 0;
      for (int c = 1; c < active_clusters(); c++)
         if (running_dist[c] < running_dist[best]) best = c;
      for (int d = 0; d < active_dims(); d++) begin
         a = best * MAX_DIMS + d;
         spread_sums[a] = add_sat(spread_sums[a], square_gap(sample_vec[d], mean_cells[a]),
                                  VSUM_SAT);
      end
      if (members[best] < CNT_SAT) members[best]++;
      if (total_vectors < CNT_SAT) total_vectors++;
      foreach (running_dist[c]) running_dist[c] = 0;
   endtask

   task automatic apply_request(mode_type m, int cl, int el, logic signed [VAL_W-1:0] v,
                                logic lst);
      stat_result r;
      longint unsigned q;
      case (m)
         MODE_LOAD: begin
            mean_cells[cl * MAX_DIMS + el] = v;
         end
         MODE_SAMPLE: begin
            if (el < active_dims()) begin
               sample_vec[el] = v;
               for (int c = 0; c < active_clusters(); c++)
                  running_dist[c] = add_sat(running_dist[c],
                                            square_gap(v, mean_cells[c * MAX_DIMS + el]),
                                            DIST_SAT);
            end
            if (lst) close_vector();
         end
         MODE_CLEAR: begin
            clear_stats();
         end
         default: begin
            r.variance = 0;
            r.weight = 0;
            r.vector_count = members[cl];
            r.empty_cluster = 1;
            if (members[cl] != 0) begin
               r.empty_cluster = 0;
               q = spread_sums[cl * MAX_DIMS + el] / members[cl];
               r.variance = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
               if (total_vectors != 0) begin
                  q = (longint'(members[cl]) << 16) / total_vectors;
                  r.weight = (q > 65536) ? 17'd65536 : q[16:0];
               end
            end
            expected_stats.push_back(r);
         end
      endcase
   endtask

   task automatic report(string field, longint unsigned exp_v, longint unsigned got_v);
      $error("%s: expected %0h, got %0h", field, exp_v, got_v);
      fail_total++;
   endtask

   always @(posedge clock) begin
      stat_result e;
      if (reset) begin
         clusters_reg = 1;
         dims_reg = 16;
         foreach (mean_cells[a]) mean_cells[a] = 0;
         foreach (sample_vec[d]) sample_vec[d] = 0;
         clear_stats();
         expected_stats.delete();
         fail_total = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_stats.size() == 0) begin
               $error("result with no pending read");
               fail_total++;
            end else begin
               e = expected_stats.pop_front();
               if (rsp_mon.variance !== e.variance)
                  report("variance", e.variance, rsp_mon.variance);
               if (rsp_mon.weight !== e.weight)
                  report("weight", e.weight, rsp_mon.weight);
               if (rsp_mon.vector_count !== e.vector_count)
                  report("vector_count", e.vector_count, rsp_mon.vector_count);
               if (rsp_mon.empty_cluster !== e.empty_cluster)
                  report("empty_cluster", e.empty_cluster, rsp_mon.empty_cluster);
            end
         end
         if (req_mon.valid && req_mon.ready)
            apply_request(mode_type'(req_mon.mode), req_mon.cluster_index,
                          req_mon.element_index, req_mon.value, req_mon.last_element);
         if (csr_we) begin
            if (csr_index == CSR_CLUSTERS) clusters_reg = csr_wdata[NCFG_W-1:0];
            else dims_reg = csr_wdata;
         end
      end
      failures <= fail_total;
      outstanding <= expected_stats.size();
   end

endmodule

/* bench/tb_nearest_mean_mixture_statistics_top.sv */
// ----------------------------------------------------------------------------
// tb_nearest_mean_mixture_statistics_top
// Drives mean loads, sample vectors, reads and clears into the mixture
// statistics block under several cluster and dimension settings, with
// random gaps on the request side and random stalls on the result side.
// A checker beside the block predicts and compares every read result.
// ----------------------------------------------------------------------------
module tb_nearest_mean_mixture_statistics_top;
   import nmms_pkg::*;

   localparam int RANDOM_ITEMS = 380;

   logic clock = 0;
   logic reset = 1;
   logic csr_we;
   logic [0:0] csr_index;
   logic [4:0] csr_wdata;
   int failures;
   int outstanding;
   int sent;
   bit req_calm;
   bit rsp_calm;
   int rsp_hold;
   int cfg_clusters;
   int cfg_dims;
   logic signed [VAL_W-1:0] mean_shadow[MAX_CLUSTERS][MAX_DIMS];

   nmms_req_if req_chan();
   nmms_rsp_if rsp_chan();

   nearest_mean_mixture_statistics_top i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   nmms_stats_checker i_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .outstanding(outstanding)
   );

   always #5 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (reset || rsp_calm) begin
         rsp_chan.ready <= 1;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_chan.ready <= 0;
         rsp_hold--;
      end else begin
         rsp_chan.ready <= 1;
         if ($urandom_range(0, 99) < 20) rsp_hold = gap_len();
      end
   end

   task automatic send(mode_type m, int cl, int el, logic [VAL_W-1:0] v, bit lst);
      int g;
      g = req_calm ? 0 : gap_len();
      if (g > 0) begin
         req_chan.valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.mode <= m;
      req_chan.cluster_index <= cl;
      req_chan.element_index <= el;
      req_chan.value <= v;
      req_chan.last_element <= lst;
      do @(posedge clock); while (!req_chan.ready);
      if (m == MODE_LOAD) mean_shadow[cl][el] = v;
      sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (outstanding != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic set_config(int nc, int nd);
      csr_we <= 1;
      csr_index <= CSR_CLUSTERS;
      csr_wdata <= nc;
      @(posedge clock);
      csr_index <= CSR_DIMS;
      csr_wdata <= nd;
      @(posedge clock);
      csr_we <= 0;
      nc = nc % 16;
      cfg_clusters = (nc == 0) ? 1 : (nc > MAX_CLUSTERS ? MAX_CLUSTERS : nc);
      cfg_dims = (nd == 0) ? 1 : (nd > MAX_DIMS ? MAX_DIMS : nd);
   endtask

   function automatic logic [VAL_W-1:0] sample_near(int c, int el);
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'h8000;
      if (r < 20) return 16'h7FFF;
      if (r < 35) return $urandom;
      v = int'(mean_shadow[c][el]) + $urandom_range(0, 600) - 300;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   task automatic random_vector();
      int tc;
      int stop_at;
      tc = $urandom_range(0, cfg_clusters - 1);
      stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cfg_dims - 1) : -1;
      for (int el = 0; el < cfg_dims; el++) begin
         if (el == stop_at) begin
            send(MODE_CLEAR, 0, 0, $urandom, 0);
            return;
         end
         if ($urandom_range(0, 9) == 0) send(MODE_SAMPLE, 0, el, sample_near(tc, el), 0);
         if (cfg_dims < MAX_DIMS && $urandom_range(0, 9) == 0)
            send(MODE_SAMPLE, $urandom, $urandom_range(cfg_dims, MAX_DIMS - 1), $urandom, 0);
         send(MODE_SAMPLE, $urandom, el, sample_near(tc, el), el == cfg_dims - 1);
      end
   endtask

   task automatic random_phase(int goal);
      int r;
      int cl;
      int el;
      req_calm = $urandom_range(0, 3) == 0;
      rsp_calm = $urandom_range(0, 3) == 0;
      while (sent < goal) begin
         r = $urandom_range(0, 99);
         if (r < 60) random_vector();
         else if (r < 82) send(MODE_READ, $urandom, $urandom, $urandom, $urandom);
         else if (r < 90) begin
            cl = $urandom_range(0, MAX_CLUSTERS - 1);
            el = $urandom_range(0, MAX_DIMS - 1);
            send(MODE_LOAD, cl, el, $urandom, $urandom);
         end else if (r < 93) send(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
         else send(MODE_SAMPLE, $urandom, $urandom, $urandom, $urandom);
      end
      req_calm = 0;
      rsp_calm = 0;
   endtask

   initial begin
      int cfg_list[8][2];
      int base;
      cfg_list = '{'{8, 16}, '{1, 1}, '{8, 1}, '{1, 16}, '{0, 0}, '{15, 31}, '{3, 7},
                   '{9, 17}};
      req_chan.valid = 0;
      req_chan.mode = MODE_LOAD;
      req_chan.cluster_index = 0;
      req_chan.element_index = 0;
      req_chan.value = 0;
      req_chan.last_element = 0;
      rsp_chan.ready = 0;
      csr_we = 0;
      csr_index = CSR_CLUSTERS;
      csr_wdata = 0;
      sent = 0;
      cfg_clusters = 1;
      cfg_dims = 16;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // every mean written up front; clusters 0 and 1 equal so ties occur
      for (int c = 0; c < MAX_CLUSTERS; c++)
         for (int d = 0; d < MAX_DIMS; d++)
            send(MODE_LOAD, c, d, (c == 1) ? mean_shadow[0][d] :
                 (c == 2 ? (d[0] ? 16'h7FFF : 16'h8000) : 16'($urandom)), 0);
      drain();
      set_config(8, 16);

      // first vector fills the whole sample buffer, extremes against extremes
      for (int d = 0; d < MAX_DIMS; d++)
         send(MODE_SAMPLE, 0, d, d[0] ? 16'h8000 : 16'h7FFF, d == MAX_DIMS - 1);
      send(MODE_READ, 2, 0, 0, 0);
      send(MODE_READ, 2, 15, 0, 0);
      send(MODE_READ, 7, 3, 0, 0);
      for (int d = 0; d < MAX_DIMS; d++)
         send(MODE_SAMPLE, 0, d, mean_shadow[0][d], d == MAX_DIMS - 1);
      send(MODE_SAMPLE, 0, 4, 16'h1234, 0);
      send(MODE_SAMPLE, 0, 4, 16'hEDCC, 1);
      send(MODE_READ, 0, 4, 0, 0);
      send(MODE_READ, 1, 4, 0, 0);
      send(MODE_CLEAR, 0, 0, 0, 0);
      send(MODE_READ, 0, 4, 0, 0);
      drain();

      base = sent;
      for (int p = 0; p < 8; p++) begin
         if (p < 8) set_config(cfg_list[p][0], cfg_list[p][1]);
         if (p == 1) begin
            send(MODE_SAMPLE, 0, 9, 16'h4000, 1);
            send(MODE_READ, 0, 0, 0, 0);
         end
         random_phase(base + (p + 1) * RANDOM_ITEMS / 8);
         drain();
         if ($urandom_range(0, 1)) set_config($urandom_range(0, 31), $urandom_range(0, 31));
      end

      if (failures == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #30000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* sim.f */
rtl/nmms_pkg.sv
rtl/nmms_if.sv
rtl/nmms_ram.sv
rtl/nmms_front.sv
rtl/nmms_div.sv
rtl/nmms_back.sv
rtl/nearest_mean_mixture_statistics_top.sv
rtl/nmms_checker.sv
bench/nmms_stats_checker.sv
bench/tb_nearest_mean_mixture_statistics_top.sv
